// ===== sv/code_length_rle_decoder_top_assert.svh =====
// assertion macros for the code length run decoder
`ifndef CODE_LENGTH_RLE_DECODER_TOP_ASSERT_SVH
`define CODE_LENGTH_RLE_DECODER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CLRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define CLRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/clrd_pkg.sv =====
// types and constants of the code length run decoder
`timescale 1ns / 1ps

package clrd_pkg;

    // symbol slicing
    localparam int unsigned SYM_BITS      = 5;
    localparam logic [4:0]  SYM_ZERO_RUN  = 5'd30;
    localparam logic [4:0]  SYM_LONG_RUN  = 5'd31;

    // table size register after reset
    localparam logic [9:0]  TABLE_ENTRIES_RESET = 10'd273;

    // pending escape
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_ZERO = 2'd1,
        ESC_HIGH = 2'd2
    } t_esc;

    // one run record
    typedef struct packed {
        logic [9:0] start_index;
        logic [4:0] length_value;
        logic [9:0] run_count;
        logic       table_full;
        logic       last_of_byte;
    } t_rec;

endpackage

// ===== sv/code_length_rle_decoder_top.sv =====
// Dataflow: an accepted item lands in the input register, is decoded once the two-entry record buffer
// can take its records, and its first record then shows on the outputs from the buffer's head slot.
// Throughput: one item per cycle while items give at most one record and i_ready is high; an item giving two
// records holds the input while both wait in the buffer, since the single output port drains one a cycle.
// Reset (synchronous, active low): decoder state and buffers empty, table_entries back to 273.
`timescale 1ns / 1ps

module code_length_rle_decoder_top
    import clrd_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 1023
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [9:0] i_cfg_wr_data,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_start_table,
    input  logic [7:0] i_data_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [9:0] o_start_index,
    output logic [4:0] o_length_value,
    output logic [9:0] o_run_count,
    output logic       o_table_full,
    output logic       o_last_of_byte
);

    localparam logic [16:0] MAX_LIM = 17'(MAX_ENTRIES);

    // configuration and input register
    logic [9:0]  r_cfg;
    logic        r_in_valid;
    logic        r_in_start;
    logic [7:0]  r_in_byte;

    // decoder state
    logic [11:0] r_buf;
    logic [3:0]  r_held;
    t_esc        r_esc;
    logic [9:0]  r_acc;
    logic [9:0]  r_done;
    logic        r_full;

    // record buffer, slot 0 is the head
    t_rec        r_ob [2];
    logic [1:0]  r_ocnt;

    // decode working values
    logic [11:0] c_buf;
    logic [3:0]  c_held;
    t_esc        c_esc;
    logic [9:0]  c_acc;
    logic [9:0]  c_done;
    logic        c_full;
    logic [11:0] c_shift;
    logic [4:0]  c_sym;
    logic [9:0]  c_run;
    logic        c_emit;
    logic [4:0]  c_elen;
    logic [9:0]  c_ecnt;
    logic [9:0]  c_rem;
    logic        c_efull;
    t_rec        c_rec;
    t_rec        c_rec_a;
    t_rec        c_rec_b;
    logic [1:0]  c_nrec;
    logic [9:0]  c_lim;
    logic        proc_go;

    // effective table size
    assign c_lim = ({7'd0, r_cfg} > MAX_LIM) ? MAX_LIM[9:0] : r_cfg;

    // decode when the buffer is empty after this cycle
    assign proc_go = r_in_valid && ((r_ocnt == 2'd0) || ((r_ocnt == 2'd1) && i_ready));
    assign o_ready = !r_in_valid || proc_go;

    // outputs from head slot
    assign o_valid        = (r_ocnt != 2'd0);
    assign o_start_index  = r_ob[0].start_index;
    assign o_length_value = r_ob[0].length_value;
    assign o_run_count    = r_ob[0].run_count;
    assign o_table_full   = r_ob[0].table_full;
    assign o_last_of_byte = r_ob[0].last_of_byte;

    // slice up to two symbols and build their records
    always_comb begin
        c_buf   = r_buf;
        c_held  = r_held;
        c_esc   = r_esc;
        c_acc   = r_acc;
        c_done  = r_done;
        c_full  = r_full;
        c_shift = '0;
        c_sym   = '0;
        c_run   = '0;
        c_emit  = 1'b0;
        c_elen  = '0;
        c_ecnt  = '0;
        c_rem   = '0;
        c_efull = 1'b0;
        c_rec   = '0;
        c_rec_a = '0;
        c_rec_b = '0;
        c_nrec  = 2'd0;
        if (r_in_start) begin
            c_buf  = '0;
            c_held = '0;
            c_esc  = ESC_NONE;
            c_acc  = '0;
            c_done = '0;
            c_full = 1'b0;
        end
        if (!c_full) begin
            c_buf  = {c_buf[3:0], r_in_byte};
            c_held = c_held + 4'd8;
            for (int k = 0; k < 2; k++) begin
                if ((c_held >= 4'(SYM_BITS)) && !c_full) begin
                    if (c_done >= c_lim) begin
                        c_full = 1'b1;
                    end else begin
                        c_held  = c_held - 4'(SYM_BITS);
                        c_shift = c_buf >> c_held;
                        c_sym   = c_shift[4:0];
                        c_emit  = 1'b0;
                        c_elen  = '0;
                        c_ecnt  = '0;
                        if (c_sym == SYM_ZERO_RUN) begin
                            c_esc = ESC_ZERO;
                        end else if (c_sym == SYM_LONG_RUN) begin
                            c_esc = ESC_HIGH;
                        end else begin
                            case (c_esc)
                                ESC_NONE: begin
                                    c_emit = 1'b1;
                                    c_elen = c_sym;
                                    c_ecnt = 10'd1;
                                end
                                ESC_ZERO: begin
                                    c_run = c_acc + {5'd0, c_sym};
                                    c_esc = ESC_NONE;
                                    c_acc = '0;
                                    if (c_run != 10'd0) begin
                                        c_emit = 1'b1;
                                        c_ecnt = c_run;
                                    end
                                end
                                ESC_HIGH: begin
                                    c_acc = {c_sym, 5'd0};
                                    c_esc = ESC_ZERO;
                                end
                                default: begin
                                    c_esc = ESC_NONE;
                                end
                            endcase
                        end
                        // clamp run at the table end
                        if (c_emit) begin
                            c_rem   = c_lim - c_done;
                            c_efull = (c_ecnt >= c_rem);
                            if (c_efull) begin
                                c_ecnt = c_rem;
                            end
                            c_rec.start_index  = c_done;
                            c_rec.length_value = c_elen;
                            c_rec.run_count    = c_ecnt;
                            c_rec.table_full   = c_efull;
                            c_rec.last_of_byte = 1'b0;
                            c_done = c_done + c_ecnt;
                            c_full = c_efull;
                            if (c_nrec == 2'd0) begin
                                c_rec_a = c_rec;
                            end else begin
                                c_rec_b = c_rec;
                            end
                            c_nrec = c_nrec + 2'd1;
                        end
                    end
                end
            end
            c_buf = c_buf & ((12'd1 << c_held) - 12'd1);
        end
        // mark the final record of the item
        if (c_nrec == 2'd2) begin
            c_rec_b.last_of_byte = 1'b1;
        end else if (c_nrec == 2'd1) begin
            c_rec_a.last_of_byte = 1'b1;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= TABLE_ENTRIES_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_start <= i_start_table;
            r_in_byte  <= i_data_byte;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_held <= '0;
            r_esc  <= ESC_NONE;
            r_acc  <= '0;
            r_done <= '0;
            r_full <= 1'b0;
        end else if (proc_go) begin
            r_buf  <= c_buf;
            r_held <= c_held;
            r_esc  <= c_esc;
            r_acc  <= c_acc;
            r_done <= c_done;
            r_full <= c_full;
        end
    end

    // record buffer count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 2'd0;
        end else if (proc_go) begin
            r_ocnt <= c_nrec;
        end else if (o_valid && i_ready) begin
            r_ocnt <= r_ocnt - 2'd1;
        end
    end

    // record buffer payload
    always_ff @(posedge i_clk) begin
        if (proc_go) begin
            r_ob[0] <= c_rec_a;
            r_ob[1] <= c_rec_b;
        end else if (o_valid && i_ready) begin
            r_ob[0] <= r_ob[1];
        end
    end

`include "code_length_rle_decoder_top_assert.svh"

    `CLRD_ASSERT_NOW(a_ocnt_range, 1'b1, r_ocnt != 2'd3, "record buffer over two entries")
    `CLRD_ASSERT_NEXT(a_full_holds, proc_go && r_full && !r_in_start, r_done == $past(r_done), "entries grew after table full")
    `CLRD_ASSERT_NOW(a_full_is_last, o_valid && o_table_full, o_last_of_byte, "full record not last of its item")
    `CLRD_ASSERT_NOW(a_no_go_when_two, r_ocnt == 2'd2, !proc_go, "decode while buffer holds two records")

endmodule
